// ----- rtl/mipd_pkg.sv -----
// Shared widths, codes, a status type and a helper function of the pair distance core.
package mipd_pkg;

    localparam int IDX_W   = 10;
    localparam int FRAC_W  = 24;
    localparam int DIFF_W  = 25;
    localparam int WRAP_W  = 21;
    localparam int COEF_W  = 21;
    localparam int ROW_W   = 63;
    localparam int ENTRY_W = 72;
    localparam int MUL_W   = 29;
    localparam int PROD_W  = 58;
    localparam int ACC_W   = 44;
    localparam int C20_W   = 28;
    localparam int SUM_W   = 58;
    localparam int RAD_W   = 50;
    localparam int ROOT_W  = 25;
    localparam int DIST_W  = 24;
    localparam int DSQ_W   = 30;
    localparam int CFG_IDX_W = 2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_CELL_ROW_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_ROW_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_ROW_Z = 2'd2;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } t_sqrt_stat;

    // Wrap a Q.20 difference to the nearest image, ties to the even integer.
    function automatic logic signed [WRAP_W-1:0] wrap_nearest(input logic signed [DIFF_W-1:0] d);
        logic [19:0] frac;
        logic        up;
        begin
            frac = d[19:0];
            up   = (frac > 20'h80000) || ((frac == 20'h80000) && d[20]);
            wrap_nearest = up ? {1'b1, frac} : {1'b0, frac};
        end
    endfunction

endpackage

// ----- rtl/mipd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mipd_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/mipd_mul.sv -----
// Shared signed multiplier with a registered product.
module mipd_mul (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [mipd_pkg::MUL_W-1:0]  i_a,
    input  logic signed [mipd_pkg::MUL_W-1:0]  i_b,
    output logic signed [mipd_pkg::PROD_W-1:0] o_prod
);
    logic signed [mipd_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;
endmodule

// ----- rtl/mipd_sqrt.sv -----
// Bit-serial integer square root, one result bit per cycle.
module mipd_sqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [mipd_pkg::RAD_W-1:0]      i_radicand,
    output mipd_pkg::t_sqrt_stat            o_stat
);
    localparam int REM_W = mipd_pkg::ROOT_W + 3;
    localparam int CNT_W = $clog2(mipd_pkg::ROOT_W);

    logic [mipd_pkg::RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]            r_rem;
    logic [mipd_pkg::ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_busy;
    logic                        r_done;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             fits;

    assign rem_sh = {r_rem[REM_W-3:0], r_rad[mipd_pkg::RAD_W-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(mipd_pkg::ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[mipd_pkg::RAD_W-3:0], 2'b00};
            r_rem  <= fits ? rem_sh - trial : rem_sh;
            r_root <= {r_root[mipd_pkg::ROOT_W-2:0], fits};
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.root = r_root;
endmodule

// ----- rtl/min_image_pair_distance_core.sv -----
// Top level of the minimum-image pair distance core.
// Keeps MAX_ATOMS fractional Q3.20 coordinate triples in a RAM and answers pair queries
// with the minimum-image distance (Q8.16) and squared distance (Q14.16) in a triclinic
// cell given by three 63-bit row registers of packed Q6.14 coefficients (column 0 in the
// low bits). A write word gives no result; a write to an index at or beyond MAX_ATOMS is
// dropped, and a query reads such an index as the origin. A query runs from acceptance
// to result through the fetch of both atoms through the single RAM read port (S_RDA,
// S_RDB, S_LDB), twelve passes of the one shared multiplier (nine matrix products,
// three squares, each issue and accumulate), a start state for the square root, the
// 25 steps of the bit-serial square root and its done flag, and the load of the output
// register, which waits while an earlier result is still held. The input is ready only
// while the sequencer is idle; a finished result waits in the output register without
// holding off the next word. Configuration writes are always taken, and an index of
// three is dropped. The coordinate store is not cleared by reset.
module min_image_pair_distance_core #(
    parameter int MAX_ATOMS = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_op,
    input  logic [mipd_pkg::IDX_W-1:0]         i_index_a,
    input  logic [mipd_pkg::IDX_W-1:0]         i_index_b,
    input  logic signed [mipd_pkg::FRAC_W-1:0] i_frac_x,
    input  logic signed [mipd_pkg::FRAC_W-1:0] i_frac_y,
    input  logic signed [mipd_pkg::FRAC_W-1:0] i_frac_z,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [mipd_pkg::DIST_W-1:0]        o_distance,
    output logic [mipd_pkg::DSQ_W-1:0]         o_distance_squared,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mipd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mipd_pkg::ROW_W-1:0]         i_cfg_data
);
    localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_RDA  = 8'b0000_0010,
        S_RDB  = 8'b0000_0100,
        S_LDB  = 8'b0000_1000,
        S_MUL  = 8'b0001_0000,
        S_SQST = 8'b0010_0000,
        S_SQRT = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // Cell matrix rows
    logic [mipd_pkg::ROW_W-1:0] r_cell [3];

    // Query context
    logic [AW-1:0] r_addr_a, r_addr_b;
    logic          r_ok_a, r_ok_b;
    logic [mipd_pkg::ENTRY_W-1:0] r_ent_a;
    logic signed [mipd_pkg::WRAP_W-1:0] r_w [3];

    // Multiply sequencer
    logic [3:0] r_cnt;
    logic       r_phase;
    logic signed [mipd_pkg::ACC_W-1:0] r_acc;
    logic [mipd_pkg::SUM_W-1:0]        r_sum;

    // Output register
    logic                        r_out_valid;
    logic [mipd_pkg::DIST_W-1:0] r_dist;
    logic [mipd_pkg::DSQ_W-1:0]  r_dsq;

    logic in_acc, cfg_acc;
    logic [31:0] ext_a, ext_b;
    logic ok_a, ok_b;
    logic ram_we;
    logic [AW-1:0] ram_raddr;
    logic [mipd_pkg::ENTRY_W-1:0] ram_rdata, ent_b;

    logic [1:0] row, slot;
    logic signed [mipd_pkg::COEF_W-1:0] coef;
    logic signed [mipd_pkg::WRAP_W-1:0] w_sel;
    logic [mipd_pkg::ACC_W-1:0]  mag;
    logic [mipd_pkg::ACC_W:0]    mag_rnd;
    logic [mipd_pkg::C20_W-1:0]  c20;
    logic signed [mipd_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic signed [mipd_pkg::PROD_W-1:0] prod;
    logic mul_en;

    logic [mipd_pkg::SUM_W:0] dsq_rnd;
    logic [34:0]              dsq_q;
    logic out_load;

    mipd_pkg::t_sqrt_stat sq_stat;

    assign in_acc      = i_in_valid && o_in_ready;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Map indexes onto the store and flag the ones beyond it
    assign ext_a = 32'(i_index_a);
    assign ext_b = 32'(i_index_b);
    assign ok_a  = ext_a < 32'(MAX_ATOMS);
    assign ok_b  = ext_b < 32'(MAX_ATOMS);

    assign ram_we    = in_acc && (i_op == mipd_pkg::OP_WRITE) && ok_a;
    assign ram_raddr = (r_state == S_RDB) ? r_addr_b : r_addr_a;

    mipd_ram #(
        .WIDTH (mipd_pkg::ENTRY_W),
        .DEPTH (MAX_ATOMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ext_a[AW-1:0]),
        .i_wdata ({i_frac_z, i_frac_y, i_frac_x}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ent_b = r_ok_b ? ram_rdata : '0;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_addr_a <= ext_a[AW-1:0];
            r_addr_b <= ext_b[AW-1:0];
            r_ok_a   <= ok_a;
            r_ok_b   <= ok_b;
        end
        if (r_state == S_RDB) begin
            r_ent_a <= r_ok_a ? ram_rdata : '0;
        end
        // Wrap each fractional difference to the nearest image
        if (r_state == S_LDB) begin
            for (int k = 0; k < 3; k++) begin
                r_w[k] <= mipd_pkg::wrap_nearest(
                    mipd_pkg::DIFF_W'($signed(r_ent_a[k*mipd_pkg::FRAC_W +: mipd_pkg::FRAC_W]))
                  - mipd_pkg::DIFF_W'($signed(ent_b[k*mipd_pkg::FRAC_W +: mipd_pkg::FRAC_W])));
            end
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell[0] <= '0;
            r_cell[1] <= '0;
            r_cell[2] <= '0;
        end else if (cfg_acc) begin
            case (i_cfg_index)
                mipd_pkg::CFG_CELL_ROW_X: r_cell[0] <= i_cfg_data;
                mipd_pkg::CFG_CELL_ROW_Y: r_cell[1] <= i_cfg_data;
                mipd_pkg::CFG_CELL_ROW_Z: r_cell[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Operand selection: slots 0..2 are row products, slot 3 squares the rounded row sum
    assign row  = r_cnt[3:2];
    assign slot = r_cnt[1:0];

    always_comb begin
        coef  = '0;
        w_sel = '0;
        case (slot)
            2'd0: w_sel = r_w[0];
            2'd1: w_sel = r_w[1];
            2'd2: w_sel = r_w[2];
            default: w_sel = '0;
        endcase
        case (row)
            2'd0: coef = r_cell[0][slot*mipd_pkg::COEF_W +: mipd_pkg::COEF_W];
            2'd1: coef = r_cell[1][slot*mipd_pkg::COEF_W +: mipd_pkg::COEF_W];
            2'd2: coef = r_cell[2][slot*mipd_pkg::COEF_W +: mipd_pkg::COEF_W];
            default: coef = '0;
        endcase
    end

    assign mag     = r_acc[mipd_pkg::ACC_W-1] ? -r_acc : r_acc;
    assign mag_rnd = {1'b0, mag} + (mipd_pkg::ACC_W+1)'(8192);
    assign c20     = mag_rnd[14 +: mipd_pkg::C20_W];

    assign mul_a  = (slot == 2'd3) ? $signed({1'b0, c20}) : mipd_pkg::MUL_W'(coef);
    assign mul_b  = (slot == 2'd3) ? $signed({1'b0, c20}) : mipd_pkg::MUL_W'(w_sel);
    assign mul_en = (r_state == S_MUL) && !r_phase;

    mipd_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == S_LDB) begin
            r_acc <= '0;
            r_sum <= '0;
        end else if ((r_state == S_MUL) && r_phase) begin
            if (slot == 2'd3) begin
                r_sum <= r_sum + $unsigned(prod);
                r_acc <= '0;
            end else begin
                r_acc <= r_acc + prod[mipd_pkg::ACC_W-1:0];
            end
        end
    end

    mipd_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_SQST),
        .i_radicand (r_sum[mipd_pkg::SUM_W-1 -: mipd_pkg::RAD_W]),
        .o_stat     (sq_stat)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_acc && (i_op == mipd_pkg::OP_QUERY)) n_state = S_RDA;
            S_RDA:  n_state = S_RDB;
            S_RDB:  n_state = S_LDB;
            S_LDB:  n_state = S_MUL;
            S_MUL:  if (r_phase && (r_cnt == 4'd11)) n_state = S_SQST;
            S_SQST: n_state = S_SQRT;
            S_SQRT: if (sq_stat.done) n_state = S_FIN;
            S_FIN:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_LDB) begin
                r_cnt   <= '0;
                r_phase <= 1'b0;
            end else if (r_state == S_MUL) begin
                r_phase <= !r_phase;
                if (r_phase) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // Round and saturate the squared distance, saturate the distance; hold them until taken
    assign dsq_rnd  = {1'b0, r_sum} + (mipd_pkg::SUM_W+1)'(1 << 23);
    assign dsq_q    = dsq_rnd[24 +: 35];
    assign out_load = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_dist <= sq_stat.root[mipd_pkg::ROOT_W-1] ? '1 : sq_stat.root[mipd_pkg::DIST_W-1:0];
            r_dsq  <= (dsq_q[34:30] != 5'd0) ? '1 : dsq_q[mipd_pkg::DSQ_W-1:0];
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_distance         = r_dist;
    assign o_distance_squared = r_dsq;

    a_query_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_op == mipd_pkg::OP_QUERY)) |=> (r_state == S_RDA))
        else $error("query did not start the fetch");

    a_root_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_stat.done |-> (r_state == S_SQRT))
        else $error("square root finished outside its wait state");

    a_mul_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_cnt <= 4'd11))
        else $error("multiply step count overran");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_dist) && $stable(r_dsq)))
        else $error("waiting result was overwritten");
endmodule
